>>> design/bitmap_chunk_allocator_defines.svh
// Assertion macros used by the chunk allocator design file.
`ifndef BITMAP_CHUNK_ALLOCATOR_DEFINES_SVH
`define BITMAP_CHUNK_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/bca_pkg.sv
// Types and constants shared by the bitmap chunk allocator.
package bca_pkg;

    localparam int SIZE_W    = 17;
    localparam int COUNT_W   = 11;
    localparam int ADDR_W    = 32;
    localparam int CIDX_W    = 10;
    localparam int CFG_IDX_W = 2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CHUNK_SIZE   = 2'd0;
    localparam t_cfg_idx CFG_CHUNK_COUNT  = 2'd1;
    localparam t_cfg_idx CFG_BASE_ADDRESS = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [SIZE_W-1:0]  RST_CHUNK_SIZE   = 17'd64;
    localparam logic [COUNT_W-1:0] RST_CHUNK_COUNT  = 11'd1024;
    localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = 32'd0;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FULL      = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_SCAN,
        S_ALLOC_MUL,
        S_ALLOC_ADDR,
        S_FREE_CHECK,
        S_FREE_LIMIT,
        S_FREE_DIV_IDX,
        S_FREE_READ,
        S_OUT
    } t_state;

endpackage

>>> design/bitmap_chunk_allocator.sv
// Allocate: a first-fit scan of the bitmap (the scan reads one word a cycle), then
// S_ALLOC_MUL and S_ALLOC_ADDR form the address; a full pool is reported from the scan.
// Free: after the range checks, a shift-subtract divider takes one quotient bit a cycle
// to find the chunk index, then clears its bitmap bit; an out-of-range free is refused.
// One request is in flight at a time; the next is taken once the result has been taken.
// Reset (synchronous, active low) restores the control and config registers, then clears
// the bitmap memory, one word a cycle, before accepting requests.
`include "bitmap_chunk_allocator_defines.svh"

module bitmap_chunk_allocator
    import bca_pkg::*;
#(
    parameter int MAX_CHUNKS    = 1024,
    parameter int BITS_PER_WORD = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    // requests
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_cmd,
    input  logic [ADDR_W-1:0]    i_free_address,
    // results
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_status,
    output logic [ADDR_W-1:0]    o_chunk_address,
    output logic [CIDX_W-1:0]    o_chunk_index
);

    localparam int IDX_W     = $clog2(MAX_CHUNKS);
    localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
    localparam int EXT_W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int MAP_WORDS = (MAX_CHUNKS + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(BITS_PER_WORD);
    localparam int PROD_W    = IDX_W + SIZE_W;
    localparam int DIV_W     = SIZE_W + IDX_W;
    localparam int CMP_W     = (DIV_W > ADDR_W) ? DIV_W : ADDR_W;
    localparam int STEP_W    = $clog2(IDX_W);
    localparam logic [BITS_PER_WORD-1:0] BIT_ONE = BITS_PER_WORD'(1);

    // control state
    t_state              r_state, n_state;
    logic [AW-1:0]       r_word;
    logic [SIZE_W-1:0]   r_chunk_size;
    logic [COUNT_W-1:0]  r_chunk_count;
    logic [ADDR_W-1:0]   r_base_address;

    // datapath registers
    logic [CNT_W-1:0]    r_wbase;
    logic [IDX_W-1:0]    r_idx;
    logic [ADDR_W-1:0]   r_faddr;
    logic [PROD_W-1:0]   r_prod;
    logic [CMP_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_div;
    logic [IDX_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_step;
    logic [BIT_W-1:0]    r_bit;
    t_status             r_status;
    logic [ADDR_W-1:0]   r_caddr;
    logic [CIDX_W-1:0]   r_cidx;

    // bitmap memory
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [BITS_PER_WORD-1:0] ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [BITS_PER_WORD-1:0] ram_rdata;

    logic [SIZE_W-1:0]        eff_size;
    logic [EXT_W-1:0]         count_ext;
    logic [CNT_W-1:0]         eff_count;
    logic                     count_zero;
    logic [IDX_W-1:0]         count_m1;
    logic [IDX_W-1:0]         mul_a;
    logic [PROD_W-1:0]        mul_p;
    logic                     accept;
    logic                     clear_last;

    logic [CNT_W-1:0]         scan_rem;
    logic                     scan_end;
    logic [BITS_PER_WORD-1:0] lane_ok;
    logic [BITS_PER_WORD-1:0] free_mask;
    logic [BIT_W-1:0]         fbit;
    logic                     scan_found;
    logic [CNT_W:0]           wbase_sum;
    logic                     more_words;
    logic                     scan_full;
    logic [IDX_W-1:0]         found_idx;

    logic                     div_ge;
    logic [CMP_W-1:0]         rem_next;
    logic [IDX_W-1:0]         quo_next;
    logic                     step_last;
    logic [IDX_W+CIDX_W-1:0]  idx_wide;

    bca_ram #(
        .WIDTH (BITS_PER_WORD),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Effective register values: a zero size acts as one, the count saturates.
    assign eff_size   = (r_chunk_size == '0) ? SIZE_W'(1) : r_chunk_size;
    assign count_ext  = EXT_W'(r_chunk_count);
    assign eff_count  = (count_ext > EXT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS)
                                                         : CNT_W'(count_ext);
    assign count_zero = (eff_count == '0);
    assign count_m1   = IDX_W'(eff_count - CNT_W'(1));

    // The one multiplier serves the allocated address and the free limit.
    assign mul_a = (r_state == S_FREE_CHECK) ? count_m1 : r_idx;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(eff_size);

    assign accept     = i_valid && o_ready;
    assign clear_last = (r_word == AW'(MAP_WORDS - 1));

    // First-fit search over the word that has just been read.
    assign scan_end = (r_wbase >= eff_count);
    assign scan_rem = eff_count - r_wbase;

    always_comb begin
        for (int b = 0; b < BITS_PER_WORD; b++) begin
            lane_ok[b] = (CNT_W'(b) < scan_rem) && !scan_end;
        end
    end

    assign free_mask = ~ram_rdata & lane_ok;

    always_comb begin
        fbit = '0;
        for (int b = BITS_PER_WORD - 1; b >= 0; b--) begin
            if (free_mask[b]) begin
                fbit = BIT_W'(b);
            end
        end
    end

    assign scan_found = |free_mask;
    assign wbase_sum  = {1'b0, r_wbase} + (CNT_W + 1)'(BITS_PER_WORD);
    assign more_words = (wbase_sum < {1'b0, eff_count});
    assign scan_full  = scan_end || (!scan_found && !more_words);
    assign found_idx  = IDX_W'(r_wbase + CNT_W'(fbit));

    // Shift-subtract divider step for the chunk index of a free.
    assign div_ge    = (r_rem >= CMP_W'(r_div));
    assign rem_next  = div_ge ? (r_rem - CMP_W'(r_div)) : r_rem;
    assign quo_next  = {r_quo[IDX_W-2:0], div_ge};
    assign step_last = (r_step == '0);

    assign idx_wide = {CIDX_W'(0), r_idx};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_cmd == CMD_ALLOC) ? S_ALLOC_SCAN : S_FREE_CHECK;
                end
            end
            S_ALLOC_SCAN: begin
                priority if (scan_full) n_state = S_OUT;
                else if (scan_found) n_state = S_ALLOC_MUL;
            end
            S_ALLOC_MUL:  n_state = S_ALLOC_ADDR;
            S_ALLOC_ADDR: n_state = S_OUT;
            S_FREE_CHECK: begin
                n_state = (count_zero || (r_faddr < r_base_address)) ? S_OUT
                                                                      : S_FREE_LIMIT;
            end
            S_FREE_LIMIT: begin
                n_state = (r_rem > CMP_W'(r_prod)) ? S_OUT : S_FREE_DIV_IDX;
            end
            S_FREE_DIV_IDX: begin
                if (step_last) n_state = S_FREE_READ;
            end
            S_FREE_READ: n_state = S_OUT;
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Handshake and memory controls
    always_comb begin
        o_ready   = 1'b0;
        o_valid   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_word;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                ram_re  = i_valid && (i_cmd == CMD_ALLOC);
            end
            S_ALLOC_SCAN: begin
                ram_we    = scan_found && !scan_end;
                ram_wdata = ram_rdata | (BIT_ONE << fbit);
                ram_re    = !scan_found && more_words;
                ram_raddr = r_word + AW'(1);
            end
            S_FREE_DIV_IDX: begin
                // The word width is a power of two, so the upper index bits pick the word.
                ram_re    = step_last;
                ram_raddr = AW'(quo_next >> BIT_W);
            end
            S_FREE_READ: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~(BIT_ONE << r_bit);
            end
            S_OUT: begin
                o_valid = 1'b1;
            end
            S_ALLOC_MUL, S_ALLOC_ADDR, S_FREE_CHECK, S_FREE_LIMIT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_word         <= '0;
            r_chunk_size   <= RST_CHUNK_SIZE;
            r_chunk_count  <= RST_CHUNK_COUNT;
            r_base_address <= RST_BASE_ADDRESS;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CHUNK_SIZE:   r_chunk_size   <= i_cfg_data[SIZE_W-1:0];
                    CFG_CHUNK_COUNT:  r_chunk_count  <= i_cfg_data[COUNT_W-1:0];
                    CFG_BASE_ADDRESS: r_base_address <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_CLEAR: r_word <= r_word + AW'(1);
                S_IDLE: begin
                    if (accept) r_word <= '0;
                end
                S_ALLOC_SCAN: begin
                    if (!scan_found && more_words) r_word <= r_word + AW'(1);
                end
                S_FREE_DIV_IDX: begin
                    if (step_last) r_word <= AW'(quo_next >> BIT_W);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_wbase <= '0;
                r_faddr <= i_free_address;
            end
            S_ALLOC_SCAN: begin
                priority if (scan_full) begin
                    r_status <= ST_FULL;
                    r_caddr  <= '0;
                    r_cidx   <= '0;
                end else if (scan_found) begin
                    r_idx <= found_idx;
                end else begin
                    r_wbase <= CNT_W'(wbase_sum);
                end
            end
            S_ALLOC_MUL: begin
                r_prod <= mul_p;
            end
            S_ALLOC_ADDR: begin
                r_status <= ST_ALLOCATED;
                r_caddr  <= r_base_address + ADDR_W'(r_prod);
                r_cidx   <= idx_wide[CIDX_W-1:0];
            end
            S_FREE_CHECK: begin
                r_status <= ST_IGNORED;
                r_caddr  <= '0;
                r_cidx   <= '0;
                r_rem    <= CMP_W'(r_faddr - r_base_address);
                r_prod   <= mul_p;
            end
            S_FREE_LIMIT: begin
                r_div  <= DIV_W'(eff_size) << (IDX_W - 1);
                r_quo  <= '0;
                r_step <= STEP_W'(IDX_W - 1);
            end
            S_FREE_DIV_IDX: begin
                r_rem  <= rem_next;
                r_quo  <= quo_next;
                r_div  <= r_div >> 1;
                r_step <= r_step - STEP_W'(1);
                if (step_last) begin
                    // Chunk index found; its low bits select the bit within the word.
                    r_idx <= quo_next;
                    r_bit <= BIT_W'(quo_next);
                end
            end
            S_FREE_READ: begin
                r_status <= ST_FREED;
                r_caddr  <= '0;
                r_cidx   <= idx_wide[CIDX_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_status        = r_status;
    assign o_chunk_address = r_caddr;
    assign o_chunk_index   = r_cidx;

    `BCA_ASSERT_NOW(a_one_request_at_a_time, i_clk, i_rst_n, o_ready, !o_valid, "request taken while a result is pending")
    `BCA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second request taken before the first finished")
    `BCA_ASSERT_NOW(a_alloc_in_range, i_clk, i_rst_n, o_valid && (r_status == ST_ALLOCATED), r_idx < eff_count, "allocated chunk lies beyond the chunk count")
    `BCA_ASSERT_NOW(a_no_write_when_quiet, i_clk, i_rst_n, (r_state == S_IDLE) || (r_state == S_OUT), !ram_we, "bitmap written outside a request")

endmodule

>>> design/bca_ram.sv
// Generic single write port, single read port RAM with registered read data.
module bca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> bench/bitmap_chunk_allocator_checker.sv
// Checker for the chunk allocator: tracks the pool, predicts each result and compares it.
`timescale 1ns / 1ps

module bitmap_chunk_allocator_checker
    import bca_pkg::*;
#(
    parameter int MAX_CHUNKS = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic                 i_cmd,
    input  logic [ADDR_W-1:0]    i_free_address,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  logic [1:0]           i_status,
    input  logic [ADDR_W-1:0]    i_chunk_address,
    input  logic [CIDX_W-1:0]    i_chunk_index,
    output int                   o_outstanding,
    output int                   o_fail_count
);

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   address;
        logic [CIDX_W-1:0]   index;
    } t_chunk_result;

    logic [MAX_CHUNKS-1:0] busy_map;
    logic [SIZE_W-1:0]     pool_size;
    logic [COUNT_W-1:0]    pool_count;
    logic [ADDR_W-1:0]     pool_base;
    t_chunk_result         pending_results[$];
    int                    mismatches;

    // Applies one request to the pool copy and returns what the block should answer.
    function automatic t_chunk_result serve_request(input logic cmd,
                                                    input logic [ADDR_W-1:0] addr);
        t_chunk_result   res;
        longint unsigned size;
        longint unsigned count;
        longint unsigned offset;
        longint unsigned slot;
        bit              found;
        res.status  = ST_FULL;
        res.address = '0;
        res.index   = '0;
        size  = (pool_size == '0) ? 1 : pool_size;
        count = (pool_count > MAX_CHUNKS) ? MAX_CHUNKS : pool_count;
        found = 1'b0;
        if (cmd == CMD_ALLOC) begin
            for (slot = 0; slot < count; slot++) begin
                if (!found && !busy_map[slot]) begin
                    found          = 1'b1;
                    busy_map[slot] = 1'b1;
                    res.status     = ST_ALLOCATED;
                    res.index      = CIDX_W'(slot);
                    res.address    = ADDR_W'(longint'(pool_base) + slot * size);
                end
            end
        end else if (count == 0 || addr < pool_base) begin
            res.status = ST_IGNORED;
        end else begin
            offset = addr - pool_base;
            // Anything past the start of the last chunk is refused, even inside it.
            if (offset > size * (count - 1)) begin
                res.status = ST_IGNORED;
            end else begin
                slot           = offset / size;
                busy_map[slot] = 1'b0;
                res.status     = ST_FREED;
                res.index      = CIDX_W'(slot);
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_chunk_result want;
        if (!i_rst_n) begin
            busy_map   = '0;
            pool_size  = RST_CHUNK_SIZE;
            pool_count = RST_CHUNK_COUNT;
            pool_base  = RST_BASE_ADDRESS;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHUNK_SIZE:   pool_size  = i_cfg_data[SIZE_W-1:0];
                    CFG_CHUNK_COUNT:  pool_count = i_cfg_data[COUNT_W-1:0];
                    CFG_BASE_ADDRESS: pool_base  = i_cfg_data;
                    default: ;
                endcase
            end
            // The result leaving at this edge can never belong to the request
            // accepted at the same edge, so it is checked first.
            if (i_res_valid && i_res_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: status %0d", i_status);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        mismatches++;
                    end
                    if (i_chunk_address !== want.address) begin
                        $error("chunk_address: expected %h, got %h",
                               want.address, i_chunk_address);
                        mismatches++;
                    end
                    if (i_chunk_index !== want.index) begin
                        $error("chunk_index: expected %0d, got %0d",
                               want.index, i_chunk_index);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                pending_results.push_back(serve_request(i_cmd, i_free_address));
        end
        o_outstanding <= pending_results.size();
        o_fail_count  <= mismatches;
    end

endmodule

>>> bench/tb_bitmap_chunk_allocator.sv
// Testbench top for the chunk allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_bitmap_chunk_allocator;
    import bca_pkg::*;

    localparam int       POOL_MAX       = 1024;
    localparam int       RANDOM_ITEMS   = 1700;
    localparam int       FILL_ITEMS     = 1100;
    localparam int       SETTLE_CYCLES  = 80;
    localparam int       CYCLE_LIMIT    = 1000000;
    localparam t_cfg_idx CFG_UNUSED     = 2'd3;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [ADDR_W-1:0]    i_cfg_data     = '0;
    logic                 i_valid        = 1'b0;
    logic                 o_ready;
    logic                 i_cmd          = CMD_ALLOC;
    logic [ADDR_W-1:0]    i_free_address = '0;
    logic                 o_valid;
    logic                 i_ready        = 1'b0;
    logic [1:0]           o_status;
    logic [ADDR_W-1:0]    o_chunk_address;
    logic [CIDX_W-1:0]    o_chunk_index;

    int outstanding;
    int fail_count;
    int send_idle_pct = 35;
    int recv_idle_pct = 70;
    int alloc_pct;
    int random_sent   = 0;
    int unsigned cycle_count = 0;

    // What the stimulus knows of the pool as the block will use it.
    longint unsigned cur_size  = 64;
    longint unsigned cur_count = POOL_MAX;
    logic [ADDR_W-1:0] cur_base = '0;

    bitmap_chunk_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_free_address  (i_free_address),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_chunk_address (o_chunk_address),
        .o_chunk_index   (o_chunk_index)
    );

    bitmap_chunk_allocator_checker #(.MAX_CHUNKS(POOL_MAX)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_cmd           (i_cmd),
        .i_free_address  (i_free_address),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_status        (o_status),
        .i_chunk_address (o_chunk_address),
        .i_chunk_index   (o_chunk_index),
        .o_outstanding   (outstanding),
        .o_fail_count    (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_free_address <= addr;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Holds the request channel quiet until every result has come back.
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [ADDR_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_pool(input logic [ADDR_W-1:0] size_data,
                            input logic [ADDR_W-1:0] count_data,
                            input logic [ADDR_W-1:0] base_data);
        wait_results_drained();
        write_register(CFG_CHUNK_SIZE, size_data);
        write_register(CFG_UNUSED, $urandom);
        write_register(CFG_CHUNK_COUNT, count_data);
        write_register(CFG_BASE_ADDRESS, base_data);
        i_cfg_valid <= 1'b0;
        cur_size  = (size_data[SIZE_W-1:0] == '0) ? 1 : size_data[SIZE_W-1:0];
        cur_count = (count_data[COUNT_W-1:0] > POOL_MAX) ? POOL_MAX
                                                         : count_data[COUNT_W-1:0];
        cur_base  = base_data;
    endtask

    // Mostly addresses inside the pool, with strays below it and past its end.
    function automatic logic [ADDR_W-1:0] pick_free_address();
        longint unsigned slot;
        longint unsigned offset;
        if (cur_count == 0)
            return $urandom;
        case ($urandom_range(9))
            0: return $urandom;
            1: return cur_base - $urandom_range(1, 64);
            2: return ADDR_W'(longint'(cur_base) + (cur_count - 1) * cur_size
                              + $urandom_range(1, 8));
            default: begin
                slot   = $urandom_range(32'(cur_count - 1));
                offset = ($urandom_range(3) == 0) ? $urandom_range(32'(cur_size - 1)) : 0;
                return ADDR_W'(longint'(cur_base) + slot * cur_size + offset);
            end
        endcase
    endfunction

    task automatic random_request();
        if (random_sent < RANDOM_ITEMS / 3) begin
            send_idle_pct  = 35;
            recv_idle_pct <= 70;
        end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 70;
            recv_idle_pct <= 35;
        end else begin
            send_idle_pct  = 0;
            recv_idle_pct <= 0;
        end
        if ($urandom_range(99) < alloc_pct)
            send_request(CMD_ALLOC, $urandom);
        else
            send_request(CMD_FREE, pick_free_address());
        random_sent++;
    endtask

    task automatic random_pool();
        logic [ADDR_W-1:0] size_val;
        logic [ADDR_W-1:0] count_val;
        logic [ADDR_W-1:0] base_val;
        case ($urandom_range(7))
            0: size_val = 0;
            1: size_val = 1;
            2: size_val = 131071;
            3: size_val = 65536;
            default: size_val = $urandom_range(1, 300);
        endcase
        case ($urandom_range(9))
            0: count_val = 0;
            1: count_val = 1;
            2: count_val = 2047;
            3: count_val = POOL_MAX;
            4: count_val = $urandom_range(POOL_MAX + 1, 2047);
            default: count_val = $urandom_range(2, 48);
        endcase
        case ($urandom_range(3))
            0: base_val = 0;
            1: base_val = 32'hFFFF_FFFF - $urandom_range(4096);
            default: base_val = $urandom;
        endcase
        // Bits above each register's width are set at random; the block drops them.
        set_pool((32'($urandom) & 32'hFFFE_0000) | size_val,
                 (32'($urandom) & 32'hFFFF_F800) | count_val, base_val);
    endtask

    initial begin
        int chunk_run;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset pool: 64-byte chunks, all 1024 in use, base zero.
        send_request(CMD_ALLOC, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32'h0);
        send_request(CMD_FREE, 32'd64);
        send_request(CMD_FREE, 32'h3F);
        send_request(CMD_FREE, 32'd0);
        send_request(CMD_FREE, 32'd65472);
        send_request(CMD_FREE, 32'd65473);
        send_request(CMD_FREE, 32'hFFFF_FFFF);

        // A size of zero acts as one byte; three chunks from address 100.
        set_pool(32'hFFFE_0000, 32'd3, 32'd100);
        repeat (4) send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'd99);
        send_request(CMD_FREE, 32'd102);
        send_request(CMD_FREE, 32'd103);

        // An empty pool refuses everything.
        set_pool(32'd1, 32'd0, 32'd100);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'd100);

        // Widest size and count above the maximum, at the top of the address space.
        set_pool(32'd131071, 32'd2047, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32'h0);
        send_request(CMD_ALLOC, 32'h0);
        send_request(CMD_FREE, 32'd0);
        send_request(CMD_FREE, 32'hFFFF_FFFF);
        send_request(CMD_ALLOC, 32'h0);

        set_pool(32'd65536, 32'd1, 32'd0);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_ALLOC, $urandom);
        send_request(CMD_FREE, 32'h0000_FFFF);
        send_request(CMD_FREE, 32'd0);

        // Whole pool in use and mostly allocations, so the scan runs to the last word.
        set_pool(32'd64, POOL_MAX, 32'h1000_0000);
        alloc_pct = 96;
        repeat (FILL_ITEMS) random_request();

        while (random_sent < RANDOM_ITEMS) begin
            random_pool();
            alloc_pct = $urandom_range(30, 70);
            chunk_run = $urandom_range(40, 90);
            while (chunk_run > 0 && random_sent < RANDOM_ITEMS) begin
                random_request();
                chunk_run--;
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
